>>> rtl/core/scpr_pkg.sv
// ----------------------------------------------------------------------------
// scpr_pkg
// Shared types and constants of the serial decimal command parser.
// ----------------------------------------------------------------------------
package scpr_pkg;

	localparam int BUFFER_DEPTH = 30;
	localparam int COUNT_W = 5;

	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_B     = 8'h42;
	localparam logic [7:0] CH_C     = 8'h43;
	localparam logic [7:0] CH_D     = 8'h44;
	localparam logic [7:0] CH_E     = 8'h45;
	localparam logic [7:0] CH_R     = 8'h52;

	localparam logic [15:0] LEVEL_BASE = 16'd4096;

	localparam logic [2:0] REG_DAC_STEP    = 3'd0;
	localparam logic [2:0] REG_DAC_OFFSET  = 3'd1;
	localparam logic [2:0] REG_DELTA_BIN1  = 3'd2;
	localparam logic [2:0] REG_DELTA_BIN2  = 3'd3;
	localparam logic [2:0] REG_DELTA_BIN3  = 3'd4;
	localparam logic [2:0] REG_DELTA_OTHER = 3'd5;

	typedef enum logic [2:0] {
		CMD_NONE  = 3'd0,
		CMD_RESET = 3'd1,
		CMD_A     = 3'd2,
		CMD_B     = 3'd3,
		CMD_C     = 3'd4,
		CMD_D     = 3'd5,
		CMD_E     = 3'd6
	} cmd_t;

	typedef enum logic [2:0] {
		PH_SPACE  = 3'b001,
		PH_DIGITS = 3'b010,
		PH_DONE   = 3'b100
	} phase_t;

	typedef struct packed {
		cmd_t        code;
		logic [15:0] n;
	} cmd_entry_t;

endpackage

>>> rtl/core/scpr_front.sv
// ----------------------------------------------------------------------------
// scpr_front
// Takes received bytes, classifies them and parses the decimal argument.
// ----------------------------------------------------------------------------
module scpr_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          rx_byte,
	input  logic                q_full,
	output logic                q_push,
	output scpr_pkg::cmd_entry_t q_entry
);
	import scpr_pkg::*;

	logic [COUNT_W-1:0] count_q;
	phase_t             phase_q;
	logic               neg_q;
	logic [15:0]        arg_q;

	cmd_t               code;
	logic               is_data;
	logic               is_digit;
	logic               is_ws;
	logic [15:0]        arg_next;
	phase_t             phase_next;
	logic               neg_next;
	logic               accum;

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
	assign is_ws    = (rx_byte == CH_SPACE) || ((rx_byte >= CH_TAB) && (rx_byte <= CH_CR));

	always_comb begin
		is_data = 1'b0;
		unique case (rx_byte)
			CH_PLUS: code = CMD_RESET;
			CH_A:    code = CMD_A;
			CH_B:    code = CMD_B;
			CH_C:    code = CMD_C;
			CH_D:    code = CMD_D;
			CH_E:    code = CMD_E;
			CH_R:    code = CMD_NONE;
			default: begin
				code    = CMD_NONE;
				is_data = 1'b1;
			end
		endcase
	end

	always_comb begin
		phase_next = phase_q;
		neg_next   = neg_q;
		accum      = 1'b0;
		unique case (phase_q)
			PH_SPACE: begin
				if (is_ws) begin
					phase_next = PH_SPACE;
				end else if (rx_byte == CH_MINUS) begin
					neg_next   = 1'b1;
					phase_next = PH_DIGITS;
				end else if (is_digit) begin
					phase_next = PH_DIGITS;
					accum      = 1'b1;
				end else begin
					phase_next = PH_DONE;
				end
			end
			PH_DIGITS: begin
				if (is_digit) begin
					accum = 1'b1;
				end else begin
					phase_next = PH_DONE;
				end
			end
			PH_DONE: phase_next = PH_DONE;
			default: phase_next = PH_DONE;
		endcase
	end

	assign arg_next = (arg_q << 3) + (arg_q << 1) + {8'd0, rx_byte - CH_ZERO};

	assign q_entry.code = code;
	assign q_entry.n    = neg_q ? (16'd0 - arg_q) : arg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			phase_q <= PH_SPACE;
			neg_q   <= 1'b0;
			arg_q   <= '0;
		end else if (q_push) begin
			if (code == CMD_RESET) begin
				count_q <= '0;
				phase_q <= PH_SPACE;
				neg_q   <= 1'b0;
				arg_q   <= '0;
			end else if (is_data && (count_q < COUNT_W'(BUFFER_DEPTH))) begin
				count_q <= count_q + 1'b1;
				phase_q <= phase_next;
				neg_q   <= neg_next;
				if (accum) begin
					arg_q <= arg_next;
				end
			end
		end
	end

endmodule

>>> rtl/core/scpr_queue.sv
// ----------------------------------------------------------------------------
// scpr_queue
// Two-entry queue of classified commands between front and back.
// ----------------------------------------------------------------------------
module scpr_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  scpr_pkg::cmd_entry_t push_entry,
	output logic                 full,
	input  logic                 pop,
	output logic                 empty,
	output scpr_pkg::cmd_entry_t head
);
	import scpr_pkg::*;

	cmd_entry_t  entries_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;

	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign head  = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

>>> rtl/core/scpr_back.sv
// ----------------------------------------------------------------------------
// scpr_back
// Carries out queued commands and holds the result register and settings.
// ----------------------------------------------------------------------------
module scpr_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_index,
	input  logic [15:0]          cfg_data,
	input  logic                 q_empty,
	input  scpr_pkg::cmd_entry_t q_head,
	output logic                 q_pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [15:0]   dac_level,
	output logic [7:0]           test_type,
	output logic [7:0]           binning_value,
	output logic [15:0]          selected_delta,
	output logic                 half_lines_mode,
	output logic [2:0]           command_seen
);
	import scpr_pkg::*;

	logic [15:0] step_q;
	logic [15:0] offset_q;
	logic [15:0] delta1_q;
	logic [15:0] delta2_q;
	logic [15:0] delta3_q;
	logic [15:0] delta_other_q;

	logic        valid_q;
	logic [15:0] level_q;
	logic [7:0]  type_q;
	logic [7:0]  bin_q;
	logic [15:0] delta_q;
	logic        mode_q;
	cmd_t        code_q;

	logic [31:0] prod;
	logic [15:0] scaled;
	logic [7:0]  bin_new;
	logic [15:0] delta_new;

	assign q_pop = !q_empty && (!valid_q || !out_stall);

	assign prod    = 32'(q_head.n) * 32'(step_q);
	assign scaled  = prod[15:0] + offset_q;
	assign bin_new = q_head.n[7:0];

	always_comb begin
		case (bin_new)
			8'd1:    delta_new = delta1_q;
			8'd2:    delta_new = delta2_q;
			8'd3:    delta_new = delta3_q;
			default: delta_new = delta_other_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q        <= 16'd1;
			offset_q      <= '0;
			delta1_q      <= '0;
			delta2_q      <= '0;
			delta3_q      <= '0;
			delta_other_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DAC_STEP:    step_q        <= cfg_data;
				REG_DAC_OFFSET:  offset_q      <= cfg_data;
				REG_DELTA_BIN1:  delta1_q      <= cfg_data;
				REG_DELTA_BIN2:  delta2_q      <= cfg_data;
				REG_DELTA_BIN3:  delta3_q      <= cfg_data;
				REG_DELTA_OTHER: delta_other_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			level_q <= LEVEL_BASE;
			type_q  <= '0;
			bin_q   <= 8'd1;
			delta_q <= '0;
			mode_q  <= 1'b0;
			code_q  <= CMD_NONE;
		end else begin
			if (q_pop) begin
				valid_q <= 1'b1;
				code_q  <= q_head.code;
				unique case (q_head.code)
					CMD_A: level_q <= LEVEL_BASE - scaled;
					CMD_B: type_q  <= q_head.n[7:0];
					CMD_C: begin
						bin_q   <= bin_new;
						delta_q <= delta_new;
					end
					CMD_D: mode_q <= 1'b0;
					CMD_E: mode_q <= 1'b1;
					default: ;
				endcase
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign out_valid       = valid_q;
	assign dac_level       = level_q;
	assign test_type       = type_q;
	assign binning_value   = bin_q;
	assign selected_delta  = delta_q;
	assign half_lines_mode = mode_q;
	assign command_seen    = code_q;

endmodule

>>> rtl/core/serial_decimal_command_parser_core.sv
// ----------------------------------------------------------------------------
// serial_decimal_command_parser_core
// Parses received serial bytes into a decimal argument and applies commands.
// ----------------------------------------------------------------------------
// usage:
// input channel in_valid/in_stall carries one received byte per transaction.
// output channel out_valid/out_stall returns one result transaction per byte:
// the current dac level, test type, binning, delta, line mode and a code
// for the byte just taken.
// settings are written through cfg_we/cfg_index/cfg_data while idle.
// out_valid rises once the byte has passed the queue entry and the back's
// result register; one byte per cycle is sustained while out_stall is low, as
// the front parse and back command update (one 16x16 multiply) add no waits.
// a two-entry queue sits between front and back; when the receiver stalls
// the result holds, the queue fills and in_stall rises after two more bytes.
// reset clears the argument, sets level to 4096, binning to 1, step to 1, the
// parse phase to space and other control state to zero; queue data is not reset.
// ----------------------------------------------------------------------------
module serial_decimal_command_parser_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         rx_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] dac_level,
	output logic [7:0]         test_type,
	output logic [7:0]         binning_value,
	output logic [15:0]        selected_delta,
	output logic               half_lines_mode,
	output logic [2:0]         command_seen
);
	import scpr_pkg::*;

	logic       q_push;
	logic       q_pop;
	logic       q_full;
	logic       q_empty;
	cmd_entry_t push_entry;
	cmd_entry_t head;

	scpr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.rx_byte  (rx_byte),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_entry  (push_entry)
	);

	scpr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (q_pop),
		.empty      (q_empty),
		.head       (head)
	);

	scpr_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.q_empty         (q_empty),
		.q_head          (head),
		.q_pop           (q_pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.dac_level       (dac_level),
		.test_type       (test_type),
		.binning_value   (binning_value),
		.selected_delta  (selected_delta),
		.half_lines_mode (half_lines_mode),
		.command_seen    (command_seen)
	);

endmodule

>>> dv/tb_serial_decimal_command_parser_core.sv
// ----------------------------------------------------------------------------
// tb_serial_decimal_command_parser_core
// Self-checking bench for the serial decimal command parser. Directed byte
// strings cover each command, the clear byte, the ignored R letter, sign and
// whitespace handling, a zero byte and a full argument buffer. Random command
// frames under several register settings follow. Every result transaction is
// compared against a cycle-free model of the parser, with random idling on
// both channels and one long output hold that backs up the input.
// ----------------------------------------------------------------------------
module tb_serial_decimal_command_parser_core;

	timeunit 1ns;
	timeprecision 1ps;

	import scpr_pkg::*;

	localparam logic [2:0] REG_SPARE = 3'd6;
	localparam logic [7:0] COMMAND_LETTERS [6] = '{CH_A, CH_B, CH_C, CH_D, CH_E, CH_R};
	localparam int FRAME_BYTES_PER_SETTING = 300;
	localparam int SETTINGS_COUNT = 6;

	typedef struct packed {
		logic signed [15:0] level;
		logic [7:0]         ttype;
		logic [7:0]         bin;
		logic [15:0]        delta;
		logic               half_lines;
		cmd_t               code;
	} parser_status_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [15:0]        cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic [7:0]         rx_byte;
	logic               out_valid;
	logic               out_stall;
	logic signed [15:0] dac_level;
	logic [7:0]         test_type;
	logic [7:0]         binning_value;
	logic [15:0]        selected_delta;
	logic               half_lines_mode;
	logic [2:0]         command_seen;

	// parser model state
	logic [15:0] cfg_shadow [6];
	int          arg_len;
	phase_t      arg_phase;
	logic        arg_neg;
	logic [15:0] arg_mag;
	logic [15:0] level_q;
	logic [7:0]  type_q;
	logic [7:0]  bin_q;
	logic [15:0] delta_q;
	logic        lines_q;

	parser_status_t pending_status [$];

	int send_gap_max = 14;
	int recv_gap_max = 14;
	int hold_cycles = 0;
	int bytes_sent = 0;
	int results_seen = 0;
	int mismatches = 0;
	int input_stall_cycles = 0;
	int long_holds = 0;
	int code_count [8];

	serial_decimal_command_parser_core dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.rx_byte         (rx_byte),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.dac_level       (dac_level),
		.test_type       (test_type),
		.binning_value   (binning_value),
		.selected_delta  (selected_delta),
		.half_lines_mode (half_lines_mode),
		.command_seen    (command_seen)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic void model_reset();
		foreach (cfg_shadow[i]) cfg_shadow[i] = 16'd0;
		cfg_shadow[REG_DAC_STEP] = 16'd1;
		arg_len = 0;
		arg_phase = PH_SPACE;
		arg_neg = 1'b0;
		arg_mag = 16'd0;
		level_q = LEVEL_BASE;
		type_q = 8'd0;
		bin_q = 8'd1;
		delta_q = 16'd0;
		lines_q = 1'b0;
	endfunction

	function automatic parser_status_t next_status(input logic [7:0] c);
		parser_status_t s;
		logic [15:0] n;
		logic [15:0] scaled;
		logic digit;
		logic blank;
		n = arg_neg ? 16'(16'd0 - arg_mag) : arg_mag;
		digit = (c >= CH_ZERO) && (c <= CH_NINE);
		blank = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
		s.code = CMD_NONE;
		case (c)
			CH_PLUS: begin
				arg_len = 0;
				arg_phase = PH_SPACE;
				arg_neg = 1'b0;
				arg_mag = 16'd0;
				s.code = CMD_RESET;
			end
			CH_A: begin
				scaled = n * cfg_shadow[REG_DAC_STEP] + cfg_shadow[REG_DAC_OFFSET];
				level_q = LEVEL_BASE - scaled;
				s.code = CMD_A;
			end
			CH_B: begin
				type_q = n[7:0];
				s.code = CMD_B;
			end
			CH_C: begin
				bin_q = n[7:0];
				case (bin_q)
					8'd1: delta_q = cfg_shadow[REG_DELTA_BIN1];
					8'd2: delta_q = cfg_shadow[REG_DELTA_BIN2];
					8'd3: delta_q = cfg_shadow[REG_DELTA_BIN3];
					default: delta_q = cfg_shadow[REG_DELTA_OTHER];
				endcase
				s.code = CMD_C;
			end
			CH_D: begin
				lines_q = 1'b0;
				s.code = CMD_D;
			end
			CH_E: begin
				lines_q = 1'b1;
				s.code = CMD_E;
			end
			CH_R: ;
			default: begin
				if (arg_len < BUFFER_DEPTH) begin
					arg_len++;
					case (arg_phase)
						PH_SPACE: begin
							if (c == CH_MINUS) begin
								arg_neg = 1'b1;
								arg_phase = PH_DIGITS;
							end else if (!blank) begin
								arg_phase = digit ? PH_DIGITS : PH_DONE;
								if (digit) arg_mag = arg_mag * 16'd10 + 16'(c - CH_ZERO);
							end
						end
						PH_DIGITS: begin
							if (digit) arg_mag = arg_mag * 16'd10 + 16'(c - CH_ZERO);
							else arg_phase = PH_DONE;
						end
						default: ;
					endcase
				end
			end
		endcase
		s.level = level_q;
		s.ttype = type_q;
		s.bin = bin_q;
		s.delta = delta_q;
		s.half_lines = lines_q;
		return s;
	endfunction

	function automatic logic [7:0] pick_blank();
		int k;
		k = $urandom_range(0, 5);
		return (k == 0) ? CH_SPACE : 8'(CH_TAB + k - 1);
	endfunction

	function automatic logic [15:0] pick_reg_value();
		case ($urandom_range(0, 3))
			0: return 16'h0000;
			1: return 16'hffff;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_byte(input logic [7:0] c);
		int gap;
		gap = $urandom_range(0, send_gap_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			rx_byte <= 8'($urandom);
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= c;
		do begin
			@(posedge clk);
			if (in_stall) input_stall_cycles++;
		end while (in_stall);
		pending_status.push_back(next_status(c));
		bytes_sent++;
	endtask

	task automatic send_text(input string text);
		foreach (text[i]) send_byte(text[i]);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_status.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_registers(input logic [15:0] step, input logic [15:0] offset,
			input logic [15:0] bin1, input logic [15:0] bin2, input logic [15:0] bin3,
			input logic [15:0] other);
		logic [15:0] vals [6];
		vals[REG_DAC_STEP] = step;
		vals[REG_DAC_OFFSET] = offset;
		vals[REG_DELTA_BIN1] = bin1;
		vals[REG_DELTA_BIN2] = bin2;
		vals[REG_DELTA_BIN3] = bin3;
		vals[REG_DELTA_OTHER] = other;
		for (int r = REG_DAC_STEP; r <= REG_DELTA_OTHER; r++) begin
			cfg_we <= 1'b1;
			cfg_index <= 3'(r);
			cfg_data <= vals[r];
			@(posedge clk);
			cfg_shadow[r] = vals[r];
		end
		// unused index, must be ignored
		cfg_index <= REG_SPARE + 3'($urandom_range(0, 1));
		cfg_data <= 16'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_frame();
		int pad;
		logic [31:0] value;
		string text;
		if ($urandom_range(0, 6) == 0) begin
			repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
			return;
		end
		if ($urandom_range(0, 9) != 0) send_byte(CH_PLUS);
		pad = ($urandom_range(0, 15) == 0) ? $urandom_range(26, 34) : $urandom_range(0, 2);
		repeat (pad) send_byte(pick_blank());
		if ($urandom_range(0, 2) == 0) send_byte(CH_MINUS);
		case ($urandom_range(0, 2))
			0: value = $urandom_range(0, 4);
			1: value = $urandom_range(0, 65535);
			default: value = $urandom;
		endcase
		text = $sformatf("%0d", value);
		if ($urandom_range(0, 3) == 0) text = {"00", text};
		if ($urandom_range(0, 7) != 0) send_text(text);
		if ($urandom_range(0, 3) == 0) send_byte(8'($urandom));
		repeat ($urandom_range(1, 3)) send_byte(COMMAND_LETTERS[$urandom_range(0, 5)]);
	endtask

	task automatic test_reset_state();
		send_byte(CH_R);
		send_byte(CH_PLUS);
		send_text("5");
		send_byte(CH_A);
	endtask

	task automatic test_commands();
		wait_idle();
		program_registers(16'd3, 16'd5, 16'h1111, 16'h2222, 16'h3333, 16'hffff);
		send_byte(CH_PLUS);
		send_byte(CH_CR);
		send_byte(CH_MINUS);
		send_text("70000");
		send_byte(CH_A);
		send_byte(CH_B);
		send_byte(CH_C);
		send_byte(CH_D);
		send_byte(CH_E);
	endtask

	task automatic test_parse_corners();
		send_byte(CH_PLUS);
		send_byte(CH_MINUS);
		send_byte(CH_C);
		send_byte(CH_PLUS);
		send_byte(CH_SPACE);
		send_text("2");
		send_byte(CH_C);
		send_byte(CH_PLUS);
		send_byte(8'h00);
		send_text("5");
		send_byte(CH_B);
	endtask

	task automatic test_buffer_full();
		send_byte(CH_PLUS);
		repeat (BUFFER_DEPTH - 1) send_byte(pick_blank());
		send_text("12");
		send_byte(8'hff);
		send_byte(CH_B);
	endtask

	task automatic test_back_pressure();
		wait_idle();
		send_gap_max = 0;
		recv_gap_max = 0;
		hold_cycles = 80;
		send_byte(CH_PLUS);
		repeat (20) send_byte(8'($urandom_range(CH_ZERO, CH_NINE)));
		send_byte(CH_A);
		send_byte(CH_C);
		send_gap_max = 14;
		recv_gap_max = 14;
	endtask

	task automatic test_random_traffic();
		int start;
		for (int p = 0; p < SETTINGS_COUNT; p++) begin
			wait_idle();
			case (p)
				0: program_registers(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
						16'h0000);
				1: program_registers(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
						16'hffff);
				default: program_registers(pick_reg_value(), pick_reg_value(),
						pick_reg_value(), pick_reg_value(), pick_reg_value(),
						pick_reg_value());
			endcase
			start = bytes_sent;
			while (bytes_sent - start < FRAME_BYTES_PER_SETTING) begin
				case ($urandom_range(0, 4))
					0: begin send_gap_max = 0; recv_gap_max = 0; end
					1: begin send_gap_max = 0; recv_gap_max = 14; end
					2: begin send_gap_max = 14; recv_gap_max = 0; end
					default: begin send_gap_max = 14; recv_gap_max = 14; end
				endcase
				send_frame();
			end
		end
	endtask

	task automatic check_field(input string what, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: transaction %0d %s expected %h, got %h", $time, results_seen,
						what, want, got);
		end
	endtask

	always @(posedge clk) begin
		parser_status_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_status.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result transaction %0d", $time, results_seen);
			end else begin
				want = pending_status.pop_front();
				code_count[want.code]++;
				check_field("dac_level", want.level, dac_level);
				check_field("test_type", want.ttype, test_type);
				check_field("binning_value", want.bin, binning_value);
				check_field("selected_delta", want.delta, selected_delta);
				check_field("half_lines_mode", want.half_lines, half_lines_mode);
				check_field("command_seen", want.code, command_seen);
			end
		end
	end

	// receiver: random stall before each result, or one long hold on request
	initial begin
		int pause;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_cycles > 0) begin
				pause = hold_cycles;
				hold_cycles = 0;
				long_holds++;
			end else begin
				pause = $urandom_range(0, recv_gap_max);
			end
			if (pause > 0) begin
				out_stall <= 1'b1;
				repeat (pause) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_byte = 8'd0;
		cfg_we = 1'b0;
		cfg_index = REG_DAC_STEP;
		cfg_data = 16'd0;
		model_reset();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_commands();
		test_parse_corners();
		test_buffer_full();
		test_back_pressure();
		test_random_traffic();
		wait_idle();
		$display("tb: %0d bytes, %0d results; A %0d B %0d C %0d D %0d E %0d clears %0d",
				bytes_sent, results_seen, code_count[CMD_A], code_count[CMD_B],
				code_count[CMD_C], code_count[CMD_D], code_count[CMD_E],
				code_count[CMD_RESET]);
		$display("tb: %0d register settings, %0d input stall cycles, %0d long holds, %0d mismatches",
				SETTINGS_COUNT + 1, input_stall_cycles, long_holds, mismatches);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
